// ----- rtl/core/mmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared types and constants for the transposed matrix multiply block.
// ----------------------------------------------------------------------------
package mmt_pkg;

  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  localparam int VALUE_W = 48;
  localparam int SIZE_W  = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_COMPUTE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic KIND_ELEMENT = 1'b0;
  localparam logic KIND_TRACE   = 1'b1;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [3:0]               row;
    logic [3:0]               col;
    logic signed [ELEM_W-1:0] a_value;
    logic signed [ELEM_W-1:0] b_value;
  } in_item_t;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic start;
    logic issue;
    logic read_done;
    logic trace_done;
    logic push;
  } ctl_t;

  typedef struct packed {
    logic issue_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/mmt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/mmt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_ctrl
// Command sequencer: accepts items, steps the compute sweep, hands results on.
// ----------------------------------------------------------------------------
module mmt_ctrl
  import mmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  input  sts_t       sts,
  output logic       in_stall,
  output ctl_t       ctl
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_COMP  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_PUSH  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.capture = accept;
        if (accept) begin
          priority if (in_cmd == CMD_LOAD) begin
            ctl.load = 1'b1;
          end else if (in_cmd == CMD_READ) begin
            state_nxt = ST_READ;
          end else if (in_cmd == CMD_COMPUTE) begin
            ctl.start = 1'b1;
            state_nxt = ST_COMP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        ctl.read_done = 1'b1;
        state_nxt     = ST_PUSH;
      end
      ST_COMP: begin
        ctl.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          ctl.trace_done = 1'b1;
          state_nxt      = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          ctl.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/mmt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_dp
// Datapath: operand and product stores, multiply-accumulate pipeline, trace,
// rank register and output register.
// ----------------------------------------------------------------------------
module mmt_dp
  import mmt_pkg::*;
#(
  parameter int MAX_RANK = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              out_stall,
  output sts_t              sts,
  output logic              out_valid,
  output out_item_t         out_data
);

  localparam int IDX_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int CELLS  = MAX_RANK * MAX_RANK;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [SIZE_W-1:0] size_r;
  logic [8:0]        size_ext;
  logic [8:0]        rank_eff;
  logic [IDX_W-1:0]  last_idx;

  logic              in_range;
  logic [ADDR_W-1:0] io_addr;
  logic              rd_inside_r;

  logic [IDX_W-1:0]  ci_r, cj_r, ck_r;
  logic [ADDR_W-1:0] a_addr, b_addr, c_wr_addr;

  logic [ELEM_W-1:0] a_rd, b_rd;
  logic [ACC_W-1:0]  c_rd;

  logic              v1_r, first1_r, last1_r;
  logic [IDX_W-1:0]  i1_r, j1_r;
  logic              v2_r, first2_r, last2_r;
  logic [IDX_W-1:0]  i2_r, j2_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic              v3_r, last3_r;
  logic [IDX_W-1:0]  i3_r, j3_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_base;

  logic [VALUE_W-1:0] trace_r;
  logic               c_we;
  out_item_t          res_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // rank clamp
  always_comb begin
    size_ext = {4'b0, size_r};
    if (size_ext == 9'd0) begin
      rank_eff = 9'd1;
    end else if (size_ext > 9'(MAX_RANK)) begin
      rank_eff = 9'(MAX_RANK);
    end else begin
      rank_eff = size_ext;
    end
    last_idx = IDX_W'(rank_eff - 9'd1);
  end

  assign in_range = ({28'b0, in_data.row} < 32'(MAX_RANK)) &&
                    ({28'b0, in_data.col} < 32'(MAX_RANK));
  assign io_addr = ADDR_W'(in_data.row) * ADDR_W'(MAX_RANK) + ADDR_W'(in_data.col);

  assign a_addr    = ADDR_W'(ci_r) * ADDR_W'(MAX_RANK) + ADDR_W'(ck_r);
  assign b_addr    = ADDR_W'(cj_r) * ADDR_W'(MAX_RANK) + ADDR_W'(ck_r);
  assign c_wr_addr = ADDR_W'(i3_r) * ADDR_W'(MAX_RANK) + ADDR_W'(j3_r);
  assign c_we      = v3_r && last3_r;

  mmt_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_left (
    .clk     (clk),
    .we      (ctl.load && in_range),
    .wr_addr (io_addr),
    .wr_data (in_data.a_value),
    .rd_addr (a_addr),
    .rd_data (a_rd)
  );

  mmt_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_right (
    .clk     (clk),
    .we      (ctl.load && in_range),
    .wr_addr (io_addr),
    .wr_data (in_data.b_value),
    .rd_addr (b_addr),
    .rd_data (b_rd)
  );

  mmt_ram #(.WIDTH(ACC_W), .DEPTH(CELLS)) u_product (
    .clk     (clk),
    .we      (c_we),
    .wr_addr (c_wr_addr),
    .wr_data (acc_r),
    .rd_addr (io_addr),
    .rd_data (c_rd)
  );

  assign prod_nxt = $signed(a_rd) * $signed(b_rd);
  assign acc_base = first2_r ? '0 : acc_r;
  assign acc_nxt  = acc_base + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  assign sts.issue_last = (ci_r == last_idx) && (cj_r == last_idx) && (ck_r == last_idx);
  assign sts.pipe_busy  = v1_r || v2_r || v3_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // rank register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_data;
    end
  end

  // sweep counters: k innermost, then j, then i
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      ci_r <= '0;
      cj_r <= '0;
      ck_r <= '0;
    end else if (ctl.issue) begin
      if (ck_r == last_idx) begin
        ck_r <= '0;
        if (cj_r == last_idx) begin
          cj_r <= '0;
          ci_r <= ci_r + 1'b1;
        end else begin
          cj_r <= cj_r + 1'b1;
        end
      end else begin
        ck_r <= ck_r + 1'b1;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    i1_r     <= ci_r;
    j1_r     <= cj_r;
    first1_r <= (ck_r == '0);
    last1_r  <= (ck_r == last_idx);
    i2_r     <= i1_r;
    j2_r     <= j1_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    prod_r   <= prod_nxt;
    i3_r     <= i2_r;
    j3_r     <= j2_r;
    last3_r  <= last2_r;
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      trace_r <= '0;
    end else if (c_we && (i3_r == j3_r)) begin
      trace_r <= trace_r + {{(VALUE_W-ACC_W){acc_r[ACC_W-1]}}, acc_r};
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      rd_inside_r <= in_range;
    end
    if (ctl.read_done) begin
      res_r.kind  <= KIND_ELEMENT;
      res_r.value <= rd_inside_r ? {{(VALUE_W-ACC_W){c_rd[ACC_W-1]}}, c_rd} : '0;
    end else if (ctl.trace_done) begin
      res_r.kind  <= KIND_TRACE;
      res_r.value <= trace_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/matrix_multiply_transposed.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_transposed
// Loads A and B element by element, computes C = A * B^T with its trace,
// and answers single elements of C on request.
//
// Input channel (in_valid / in_stall / in_data): one command per transfer.
//   Load is written to the stores as it is taken; the next command can follow at once.
//   Read answers kind 0 through the READ and PUSH states into the output register.
//   Compute runs n*n*n multiply-accumulate steps over the two operand
//   RAMs (one A and one B read per cycle), drains the pipeline, then answers
//   kind 1 with the trace. n is the rank in use.
// Result channel (out_valid / out_stall / out_data): one output register.
//   While it is stalled the block keeps taking loads; a read or compute
//   waits with its result until the register frees.
// Config channel (cfg_valid / cfg_ready / cfg_data): rank in use, always
//   ready; write only while idle.
// Reset: rank returns to 16, output empty. Store contents stay undefined
//   until loaded or computed.
// ----------------------------------------------------------------------------
module matrix_multiply_transposed
  import mmt_pkg::*;
#(
  parameter int MAX_RANK = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .sts      (sts),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  mmt_dp #(.MAX_RANK(MAX_RANK)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/mmt_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_chk
// Port-level checks for the transposed matrix multiply block.
// ----------------------------------------------------------------------------
module mmt_chk
  import mmt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic in_xfer;

  assign in_xfer = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_data.cmd == CMD_READ || in_data.cmd == CMD_COMPUTE) |=> in_stall)
    else $error("block not busy after read or compute transfer");

  a_free_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.cmd != CMD_READ && in_data.cmd != CMD_COMPUTE |=> !in_stall)
    else $error("block stalled after load");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while block idle");

endmodule

bind matrix_multiply_transposed mmt_chk u_mmt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the transposed matrix multiply: loads A and B, computes
// C = A * B^T with its trace and reads single C entries back. Every result
// is checked against a local model of the stores, across several ranks,
// with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import mmt_pkg::*;

  localparam int RANK = 16;
  localparam int CELLS = RANK * RANK;
  localparam int SETTLE = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1100;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;

  logic signed [ELEM_W-1:0] a_elem [CELLS];
  logic signed [ELEM_W-1:0] b_elem [CELLS];
  longint c_elem [CELLS];
  logic [SIZE_W-1:0] rank_reg;
  out_item_t answer_q [$];

  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 0;

  matrix_multiply_transposed #(.MAX_RANK(RANK)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int rank_in_use(input logic [SIZE_W-1:0] size);
    if (size < 1) return 1;
    if (size > RANK) return RANK;
    return int'(size);
  endfunction

  function automatic longint form_product();
    int n;
    longint acc;
    longint trace_sum;
    n = rank_in_use(rank_reg);
    trace_sum = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += longint'(a_elem[i * RANK + k]) * longint'(b_elem[j * RANK + k]);
        end
        c_elem[i * RANK + j] = acc;
      end
      trace_sum += c_elem[i * RANK + i];
    end
    return trace_sum;
  endfunction

  function automatic void apply_command(input in_item_t item);
    int slot;
    out_item_t ans;
    longint sum;
    slot = item.row * RANK + item.col;
    case (item.cmd)
      CMD_LOAD: begin
        a_elem[slot] = item.a_value;
        b_elem[slot] = item.b_value;
      end
      CMD_COMPUTE: begin
        sum = form_product();
        ans.kind = KIND_TRACE;
        ans.value = sum[VALUE_W-1:0];
        answer_q.push_back(ans);
      end
      CMD_READ: begin
        sum = c_elem[slot];
        ans.kind = KIND_ELEMENT;
        ans.value = sum[VALUE_W-1:0];
        answer_q.push_back(ans);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [3:0] row, col,
                                         input logic signed [ELEM_W-1:0] a, b);
    in_item_t item;
    item.cmd = cmd;
    item.row = row;
    item.col = col;
    item.a_value = a;
    item.b_value = b;
    return item;
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3: return -16'sd1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_rank();
    case ($urandom_range(0, 9))
      0: return SIZE_W'(RANK);
      1: return SIZE_W'($urandom_range(RANK + 1, 31));
      2: return '0;
      3, 4: return SIZE_W'($urandom_range(7, 12));
      default: return SIZE_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 100) $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    apply_command(item);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rank(input logic [SIZE_W-1:0] size);
    drain_and_settle();
    cfg_valid <= 1'b1;
    cfg_data <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rank_reg = size;
  endtask

  task automatic fill_all(input logic signed [ELEM_W-1:0] a, b);
    for (int slot = 0; slot < CELLS; slot++) begin
      send_item(make_item(CMD_LOAD, 4'(slot / RANK), 4'(slot % RANK), a, b));
    end
  endtask

  // full rank at reset; leaves every A, B and C entry defined
  task automatic test_full_scale();
    fill_all(-16'sd32768, -16'sd32768);
    send_item(make_item(CMD_COMPUTE, '0, '0, '0, '0));
    send_item(make_item(CMD_READ, 4'd0, 4'd0, '0, '0));
    send_item(make_item(CMD_READ, 4'd15, 4'd15, '0, '0));
    send_item(make_item(CMD_READ, 4'd7, 4'd3, '0, '0));
    fill_all(-16'sd32768, 16'sd32767);
    send_item(make_item(CMD_COMPUTE, '0, '0, '0, '0));
    send_item(make_item(CMD_READ, 4'd15, 4'd0, '0, '0));
    send_item(make_item(CMD_READ, 4'd0, 4'd15, '0, '0));
  endtask

  task automatic test_corners();
    write_rank(5'd1);
    send_item(make_item(CMD_LOAD, 4'd0, 4'd0, 16'sd32767, 16'sd32767));
    send_item(make_item(CMD_LOAD, 4'd15, 4'd15, -16'sd32768, -16'sd1));
    send_item(make_item(CMD_COMPUTE, '0, '0, '0, '0));
    send_item(make_item(CMD_READ, 4'd0, 4'd0, '0, '0));
    send_item(make_item(CMD_READ, 4'd15, 4'd15, '0, '0));
    send_item(make_item(CMD_READ, 4'd0, 4'd1, '0, '0));
    send_item(make_item(CMD_SPARE, 4'd15, 4'd15, -16'sd1, -16'sd1));
    write_rank(5'd0);
    send_item(make_item(CMD_COMPUTE, '0, '0, '0, '0));
    write_rank(5'd2);
    send_item(make_item(CMD_LOAD, 4'd0, 4'd1, -16'sd32768, 16'sd1));
    send_item(make_item(CMD_LOAD, 4'd1, 4'd0, 16'sd0, -16'sd32768));
    send_item(make_item(CMD_LOAD, 4'd1, 4'd1, -16'sd1, 16'sd32767));
    send_item(make_item(CMD_COMPUTE, '0, '0, '0, '0));
    send_item(make_item(CMD_READ, 4'd1, 4'd0, '0, '0));
    send_item(make_item(CMD_READ, 4'd1, 4'd1, '0, '0));
    send_item(make_item(CMD_READ, 4'd0, 4'd1, '0, '0));
    write_rank(5'd31);
    send_item(make_item(CMD_COMPUTE, '0, '0, '0, '0));
    send_item(make_item(CMD_READ, 4'd15, 4'd15, '0, '0));
    send_item(make_item(CMD_READ, 4'd0, 4'd0, '0, '0));
  endtask

  task automatic test_random();
    int sent;
    int quota;
    int n;
    int choice;
    logic [3:0] row;
    logic [3:0] col;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_rank(pick_rank());
      n = rank_in_use(rank_reg);
      quota = $urandom_range(60, 180);
      repeat (quota) begin
        choice = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 8) begin
          row = 4'($urandom_range(0, n - 1));
          col = 4'($urandom_range(0, n - 1));
        end else begin
          row = 4'($urandom);
          col = 4'($urandom);
        end
        if (choice < 5) begin
          send_item(make_item(CMD_SPARE, 4'($urandom), 4'($urandom), ELEM_W'($urandom),
                              ELEM_W'($urandom)));
        end else begin
          sent++;
          if (choice < 50) begin
            send_item(make_item(CMD_LOAD, row, col, pick_elem(), pick_elem()));
          end else if (choice < 57) begin
            send_item(make_item(CMD_COMPUTE, 4'($urandom), 4'($urandom), ELEM_W'($urandom),
                                ELEM_W'($urandom)));
          end else begin
            send_item(make_item(CMD_READ, row, col, ELEM_W'($urandom), ELEM_W'($urandom)));
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin : check_answers
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer kind %0d value %0d",
                                  out_data.kind, out_data.value));
      end else begin
        want = answer_q.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_data.kind, want.kind));
        if (out_data.value !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d", out_data.value, want.value));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rank_reg = SIZE_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_full_scale();
    test_corners();
    test_random();
    drain_and_settle();
    if (answer_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", answer_q.size()));
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
